>>> hdl/vaxn_pkg.sv
// shared types and constants for the variation axis normalizer
`default_nettype none
package vaxn_pkg;

  localparam int REMAP_POINTS = 8;
  localparam int DIV1_STEPS   = 15;
  localparam int DIV2_STEPS   = 18;
  localparam int REM_W        = 32;
  localparam int NUM_W        = 18;
  localparam int DEN_W        = 32;
  localparam int QUO_W        = 18;

  localparam logic [2:0] REG_MIN   = 3'd0;
  localparam logic [2:0] REG_DEF   = 3'd1;
  localparam logic [2:0] REG_MAX   = 3'd2;
  localparam logic [2:0] REG_COUNT = 3'd3;
  localparam logic [2:0] REG_PTS01 = 3'd4;
  localparam logic [2:0] REG_PTS23 = 3'd5;
  localparam logic [2:0] REG_PTS45 = 3'd6;
  localparam logic [2:0] REG_PTS67 = 3'd7;

  localparam logic signed [15:0] NORM_POS_ONE = 16'sd16384;
  localparam logic signed [15:0] NORM_NEG_ONE = -16'sd16384;

  typedef struct packed {
    logic [31:0]        coord;
    logic               frc;
    logic signed [15:0] frc_val;
    logic               neg;
    logic signed [15:0] pto;
  } side_t;

  typedef struct packed {
    logic             valid;
    logic [REM_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
    side_t            side;
  } cell_t;

endpackage
`default_nettype wire

>>> hdl/vaxn_div_cell.sv
// one restoring divide step with its own pipeline register
`default_nettype none
module vaxn_div_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  vaxn_pkg::cell_t     up_i,
  output logic                up_ready_o,
  output vaxn_pkg::cell_t     dn_o,
  input  wire logic           dn_ready_i
);

  vaxn_pkg::cell_t cell_r, cell_nxt;
  logic [vaxn_pkg::REM_W:0] trial;
  logic [vaxn_pkg::REM_W:0] diff;

  always_comb begin
    trial    = {up_i.rem, up_i.num[vaxn_pkg::NUM_W-1]};
    diff     = trial - {1'b0, up_i.den};
    cell_nxt = up_i;
    cell_nxt.num = {up_i.num[vaxn_pkg::NUM_W-2:0], 1'b0};
    if (trial >= {1'b0, up_i.den}) begin
      cell_nxt.rem = diff[vaxn_pkg::REM_W-1:0];
      cell_nxt.quo = {up_i.quo[vaxn_pkg::QUO_W-2:0], 1'b1};
    end else begin
      cell_nxt.rem = trial[vaxn_pkg::REM_W-1:0];
      cell_nxt.quo = {up_i.quo[vaxn_pkg::QUO_W-2:0], 1'b0};
    end
  end

  assign up_ready_o = !cell_r.valid || dn_ready_i;
  assign dn_o       = cell_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (up_ready_o) begin
      cell_r <= cell_nxt;
    end
  end

  // partial remainder stays below the divisor on live divisions
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cell_r.valid && !cell_r.side.frc |-> cell_r.rem < cell_r.den)
    else $error("remainder not below divisor");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cell_r.valid && !dn_ready_i |=> $stable(cell_r))
    else $error("stalled cell changed");

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    up_i.valid && up_ready_o |=> cell_r.valid)
    else $error("request dropped in cell");

endmodule
`default_nettype wire

>>> hdl/variation_axis_normalizer.sv
// variation axis normalizer top level: clamp, normalize divider chain, remap divider chain
// pipeline from request accept to out_valid: 2 setup stages, 15 divide cells,
//   3 remap setup stages incl. one multiply, 18 divide cells, 1 output register
// throughput: one request per cycle; every stage holds one request and moves on
//   whenever the stage after it is empty or moving
// reset: synchronous active-low rst_n clears all valid bits and all config registers
`default_nettype none
module variation_axis_normalizer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_coord_given,
  input  wire logic signed [31:0] in_requested_coord,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_clamped_coord,
  output logic signed [15:0]      out_norm_coord,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_wdata
);

  localparam int D1 = vaxn_pkg::DIV1_STEPS;
  localparam int D2 = vaxn_pkg::DIV2_STEPS;

  logic signed [31:0] mn_r, df_r, mx_r;
  logic [3:0]         cnt_r;
  logic [63:0]        pts_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mn_r  <= '0;
      df_r  <= '0;
      mx_r  <= '0;
      cnt_r <= '0;
      for (int i = 0; i < 4; i++) pts_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vaxn_pkg::REG_MIN:   mn_r     <= cfg_wdata[31:0];
        vaxn_pkg::REG_DEF:   df_r     <= cfg_wdata[31:0];
        vaxn_pkg::REG_MAX:   mx_r     <= cfg_wdata[31:0];
        vaxn_pkg::REG_COUNT: cnt_r    <= cfg_wdata[3:0];
        vaxn_pkg::REG_PTS01: pts_r[0] <= cfg_wdata;
        vaxn_pkg::REG_PTS23: pts_r[1] <= cfg_wdata;
        vaxn_pkg::REG_PTS45: pts_r[2] <= cfg_wdata;
        vaxn_pkg::REG_PTS67: pts_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage enables, walking back from the output register
  logic en_s1, en_s2, en_s3, en_s4, en_s5, en_out;
  vaxn_pkg::cell_t d1_q [D1+1];
  logic            d1_rdy [D1+1];
  vaxn_pkg::cell_t d2_q [D2+1];
  logic            d2_rdy [D2+1];

  logic out_v_r;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;

  assign en_out = !out_v_r || out_ready;
  assign d2_rdy[D2] = en_out;
  assign en_s5  = !s5_v_r || d2_rdy[0];
  assign en_s4  = !s4_v_r || en_s5;
  assign en_s3  = !s3_v_r || en_s4;
  assign d1_rdy[D1] = en_s3;
  assign en_s2  = !s2_v_r || d1_rdy[0];
  assign en_s1  = !s1_v_r || en_s2;
  assign in_ready = en_s1;

  // stage 1: default substitution and clamp
  logic signed [31:0] clamp_c, s1_coord_r;

  always_comb begin
    if (in_coord_given) begin
      if (in_requested_coord < mn_r)      clamp_c = mn_r;
      else if (in_requested_coord > mx_r) clamp_c = mx_r;
      else                                clamp_c = in_requested_coord;
    end else begin
      clamp_c = df_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en_s1) begin
      s1_v_r     <= in_valid;
      s1_coord_r <= clamp_c;
    end
  end

  // stage 2: offset from default and span of the chosen side
  logic signed [32:0] diff_c, span_c, absd_c;
  logic               zero_c, sat_c;
  logic [31:0]        s2_coord_r, mag_r, d_r;
  logic               neg_r, zero_r, sat_r;

  always_comb begin
    diff_c = {s1_coord_r[31], s1_coord_r} - {df_r[31], df_r};
    if (s1_coord_r <= df_r) span_c = {df_r[31], df_r} - {mn_r[31], mn_r};
    else                    span_c = {mx_r[31], mx_r} - {df_r[31], df_r};
    absd_c = diff_c[32] ? -diff_c : diff_c;
    zero_c = span_c[32] || (span_c == '0);
    sat_c  = absd_c[31:0] >= span_c[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en_s2) begin
      s2_v_r     <= s1_v_r;
      s2_coord_r <= s1_coord_r;
      mag_r      <= absd_c[31:0];
      d_r        <= span_c[31:0];
      neg_r      <= diff_c[32];
      zero_r     <= zero_c;
      sat_r      <= sat_c;
    end
  end

  // normalize chain: floor(mag * 2^15 / d), rounded afterwards
  always_comb begin
    d1_q[0].valid        = s2_v_r;
    d1_q[0].rem          = mag_r;
    d1_q[0].num          = '0;
    d1_q[0].den          = d_r;
    d1_q[0].quo          = '0;
    d1_q[0].side.coord   = s2_coord_r;
    d1_q[0].side.frc     = zero_r || sat_r;
    d1_q[0].side.frc_val = zero_r ? 16'sd0 :
                           (neg_r ? vaxn_pkg::NORM_NEG_ONE : vaxn_pkg::NORM_POS_ONE);
    d1_q[0].side.neg     = neg_r;
    d1_q[0].side.pto     = '0;
  end

  for (genvar k = 0; k < D1; k++) begin : g_div1
    vaxn_div_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .up_i       (d1_q[k]),
      .up_ready_o (d1_rdy[k]),
      .dn_o       (d1_q[k+1]),
      .dn_ready_i (d1_rdy[k+1])
    );
  end

  // stage 3: round and sign the normalized value
  logic [D1:0]        n_rnd_c;
  logic signed [15:0] norm_c, s3_norm_r;
  logic [31:0]        s3_coord_r;

  always_comb begin
    n_rnd_c = {1'b0, d1_q[D1].quo[D1-1:0]} + 1'b1;
    if (d1_q[D1].side.frc)     norm_c = d1_q[D1].side.frc_val;
    else if (d1_q[D1].side.neg) norm_c = -$signed({1'b0, n_rnd_c[D1:1]});
    else                       norm_c = $signed({1'b0, n_rnd_c[D1:1]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en_s3) begin
      s3_v_r     <= d1_q[D1].valid;
      s3_coord_r <= d1_q[D1].side.coord;
      s3_norm_r  <= norm_c;
    end
  end

  // stage 4: remap segment search
  logic signed [15:0] pfr [8];
  logic signed [15:0] ptv [8];
  logic [3:0]         n_pts;
  logic [2:0]         seg, last_idx;
  logic               found, byp_c;
  logic signed [15:0] bval_c;
  logic signed [16:0] sspan_c, xpf_c, dto_c, adto_c;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pfr[k] = pts_r[k >> 1][(k & 1) * 32 +: 16];
      ptv[k] = pts_r[k >> 1][(k & 1) * 32 + 16 +: 16];
    end
    n_pts    = (cnt_r > 4'(vaxn_pkg::REMAP_POINTS)) ? 4'(vaxn_pkg::REMAP_POINTS) : cnt_r;
    last_idx = 3'(n_pts - 4'd1);
    found    = 1'b0;
    seg      = 3'd0;
    byp_c    = 1'b1;
    bval_c   = s3_norm_r;
    if (n_pts == 4'd0) begin
      bval_c = s3_norm_r;
    end else if (s3_norm_r <= pfr[0]) begin
      bval_c = ptv[0];
    end else begin
      bval_c = ptv[last_idx];
      for (int i = 1; i < vaxn_pkg::REMAP_POINTS; i++) begin
        if (!found && (4'(i) < n_pts) && (s3_norm_r <= pfr[i])) begin
          found = 1'b1;
          seg   = 3'(i);
        end
      end
    end
    sspan_c = {pfr[seg][15], pfr[seg]} - {pfr[seg-3'd1][15], pfr[seg-3'd1]};
    xpf_c   = {s3_norm_r[15], s3_norm_r} - {pfr[seg-3'd1][15], pfr[seg-3'd1]};
    dto_c   = {ptv[seg][15], ptv[seg]} - {ptv[seg-3'd1][15], ptv[seg-3'd1]};
    adto_c  = dto_c[16] ? -dto_c : dto_c;
    if (found) begin
      if (sspan_c[16] || (sspan_c == '0)) begin
        bval_c = ptv[seg];
      end else begin
        byp_c = 1'b0;
      end
    end
  end

  logic [31:0]        s4_coord_r;
  logic               s4_byp_r, s4_dneg_r;
  logic signed [15:0] s4_bval_r, s4_pto_r;
  logic [15:0]        s4_xpf_r, s4_den_r, s4_adto_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en_s4) begin
      s4_v_r     <= s3_v_r;
      s4_coord_r <= s3_coord_r;
      s4_byp_r   <= byp_c;
      s4_bval_r  <= bval_c;
      s4_xpf_r   <= xpf_c[15:0];
      s4_den_r   <= sspan_c[15:0];
      s4_adto_r  <= adto_c[15:0];
      s4_dneg_r  <= dto_c[16];
      s4_pto_r   <= ptv[seg-3'd1];
    end
  end

  // stage 5: interpolation product
  logic [31:0]        s5_coord_r, s5_prod_r;
  logic               s5_byp_r, s5_dneg_r;
  logic signed [15:0] s5_bval_r, s5_pto_r;
  logic [15:0]        s5_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en_s5) begin
      s5_v_r     <= s4_v_r;
      s5_coord_r <= s4_coord_r;
      s5_prod_r  <= s4_xpf_r * s4_adto_r;
      s5_byp_r   <= s4_byp_r;
      s5_bval_r  <= s4_bval_r;
      s5_dneg_r  <= s4_dneg_r;
      s5_pto_r   <= s4_pto_r;
      s5_den_r   <= s4_den_r;
    end
  end

  // remap chain: floor(2 * prod / span), top bits preloaded as remainder
  logic [32:0] n2_c;

  always_comb begin
    n2_c                 = {s5_prod_r, 1'b0};
    d2_q[0].valid        = s5_v_r;
    d2_q[0].rem          = vaxn_pkg::REM_W'(n2_c >> vaxn_pkg::NUM_W);
    d2_q[0].num          = n2_c[vaxn_pkg::NUM_W-1:0];
    d2_q[0].den          = vaxn_pkg::DEN_W'(s5_den_r);
    d2_q[0].quo          = '0;
    d2_q[0].side.coord   = s5_coord_r;
    d2_q[0].side.frc     = s5_byp_r;
    d2_q[0].side.frc_val = s5_bval_r;
    d2_q[0].side.neg     = s5_dneg_r;
    d2_q[0].side.pto     = s5_pto_r;
  end

  for (genvar k = 0; k < D2; k++) begin : g_div2
    vaxn_div_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .up_i       (d2_q[k]),
      .up_ready_o (d2_rdy[k]),
      .dn_o       (d2_q[k+1]),
      .dn_ready_i (d2_rdy[k+1])
    );
  end

  // output stage: round, offset by the segment start, saturate
  logic [vaxn_pkg::QUO_W:0] q_rnd_c;
  logic signed [18:0]       res_c, pto_x;
  logic signed [15:0]       sat_res_c;
  logic signed [31:0]       out_coord_r;
  logic signed [15:0]       out_norm_r;

  always_comb begin
    q_rnd_c = {1'b0, d2_q[D2].quo} + 1'b1;
    pto_x   = {{3{d2_q[D2].side.pto[15]}}, d2_q[D2].side.pto};
    if (d2_q[D2].side.frc) begin
      res_c = {{3{d2_q[D2].side.frc_val[15]}}, d2_q[D2].side.frc_val};
    end else if (d2_q[D2].side.neg) begin
      res_c = pto_x - $signed({1'b0, q_rnd_c[vaxn_pkg::QUO_W:1]});
    end else begin
      res_c = pto_x + $signed({1'b0, q_rnd_c[vaxn_pkg::QUO_W:1]});
    end
    if (res_c > 19'sd16384)       sat_res_c = vaxn_pkg::NORM_POS_ONE;
    else if (res_c < -19'sd16384) sat_res_c = vaxn_pkg::NORM_NEG_ONE;
    else                          sat_res_c = res_c[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en_out) begin
      out_v_r     <= d2_q[D2].valid;
      out_coord_r <= d2_q[D2].side.coord;
      out_norm_r  <= sat_res_c;
    end
  end

  assign out_valid         = out_v_r;
  assign out_clamped_coord = out_coord_r;
  assign out_norm_coord    = out_norm_r;

endmodule
`default_nettype wire
